/* hw/rtl/oam_pkg.sv */
// Shared types, codes and constants for the oversampled ADC autorange meter.
// Used by the channel interfaces and by the datapath, controller and top level.
`timescale 1ns / 1ps
`default_nettype none

package oam_pkg;

  localparam int OPCODE_W = 2;
  localparam int RANGE_W  = 3;
  localparam int CODE_W   = 16;
  localparam int KIND_W   = 2;
  localparam int SUM_W    = 24;
  localparam int CNT_W    = 8;
  localparam int UV_W     = 22;
  localparam int PROD_W   = UV_W + SUM_W;
  localparam int REG_IDX_W = 3;
  localparam int REG_DATA_W = 22;

  localparam logic [OPCODE_W-1:0] OP_SET_RANGE = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_START     = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_SAMPLE    = 2'd2;

  localparam logic [KIND_W-1:0] KIND_APPLIED = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REQUEST = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DONE    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_IGNORED = 2'd3;

  localparam logic [REG_IDX_W-1:0] REG_OVERSAMPLE = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_AUTOSCALE  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_LOW_THR    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_HIGH_THR   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_AMP_ON     = 3'd4;

  localparam logic [CNT_W-1:0] RST_OVERSAMPLE = 8'd16;
  localparam logic [UV_W-1:0]  RST_LOW_THR    = 22'd50000;
  localparam logic [UV_W-1:0]  RST_HIGH_THR   = 22'd3200000;

  localparam logic [UV_W-1:0] FULL_SCALE_UV = 22'd3300000;

  localparam logic [RANGE_W-1:0] RANGE_MIN = 3'd0;
  localparam logic [RANGE_W-1:0] RANGE_MAX = 3'd7;

  localparam logic [2:0] MUX_TZ0 = 3'b000;
  localparam logic [2:0] MUX_TZ1 = 3'b010;
  localparam logic [2:0] MUX_TZ2 = 3'b101;
  localparam logic [2:0] MUX_TZ3 = 3'b001;

  typedef struct packed {
    logic accept;
    logic load_prod;
    logic div_start;
    logic div_num;
    logic store_avg;
    logic finish;
  } oam_cmd_t;

  typedef struct packed {
    logic last_sample;
    logic div_done;
    logic out_free;
  } oam_stat_t;

  function automatic logic [2:0] mux_code(input logic [RANGE_W-1:0] rng, input logic amp_on);
    logic [2:0] c;
    begin
      case (rng[2:1])
        2'd0: c = MUX_TZ0;
        2'd1: c = MUX_TZ1;
        2'd2: c = MUX_TZ2;
        default: c = MUX_TZ3;
      endcase
      mux_code = amp_on ? c : 3'b000;
    end
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/oam_if.sv */
// Valid/ready channel interfaces for command items, result items and register writes.
// Depends on oam_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface oam_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [oam_pkg::OPCODE_W-1:0]  opcode;
  logic [oam_pkg::RANGE_W-1:0]   range_value;
  logic [oam_pkg::CODE_W-1:0]    sample_code;
  modport source(output valid, opcode, range_value, sample_code, input ready);
  modport sink(input valid, opcode, range_value, sample_code, output ready);
endinterface

interface oam_res_if;
  logic                        valid;
  logic                        ready;
  logic [oam_pkg::KIND_W-1:0]  result_kind;
  logic [2:0]                  mux_select;
  logic                        stage_select;
  logic [oam_pkg::CODE_W-1:0]  average_code;
  logic [oam_pkg::UV_W-1:0]    level_uv;
  logic [oam_pkg::RANGE_W-1:0] measured_range;
  logic [oam_pkg::RANGE_W-1:0] next_range;
  modport source(output valid, result_kind, mux_select, stage_select, average_code,
                 level_uv, measured_range, next_range, input ready);
  modport sink(input valid, result_kind, mux_select, stage_select, average_code,
               level_uv, measured_range, next_range, output ready);
endinterface

interface oam_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [oam_pkg::REG_IDX_W-1:0]   index;
  logic [oam_pkg::REG_DATA_W-1:0]  data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/oam_div.sv */
// Restoring radix-2 divider, one quotient bit per cycle.
// Standalone; used by the datapath for the mean and the microvolt level.
`timescale 1ns / 1ps
`default_nettype none

module oam_div #(
  parameter int DW = 46,
  parameter int VW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic [DW-1:0] quo,
  output logic [VW-1:0] rem,
  output logic          done
);

  localparam int CW = $clog2(DW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [VW:0]   shifted;
  logic [VW:0]   diff;

  assign shifted = {rem, quo[DW-1]};
  assign diff    = shifted - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(DW);
      done <= 1'b0;
    end else if (busy) begin
      cnt  <= cnt - CW'(1);
      done <= (cnt == CW'(1));
      busy <= (cnt != CW'(1));
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      if (!diff[VW]) begin
        rem <= diff[VW-1:0];
        quo <= {quo[DW-2:0], 1'b1};
      end else begin
        rem <= shifted[VW-1:0];
        quo <= {quo[DW-2:0], 1'b0};
      end
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while still busy");

endmodule

`default_nettype wire

/* hw/rtl/oam_datapath.sv */
// Datapath: configuration registers, accumulator, range state, divider and result register.
// Depends on oam_pkg, oam_cfg_if and oam_div.
`timescale 1ns / 1ps
`default_nettype none

module oam_datapath #(
  parameter int SAMPLE_BITS    = 16,
  parameter int MAX_OVERSAMPLE = 255
) (
  input  logic                          clk,
  input  logic                          rst,
  oam_cfg_if.sink                       cfg,
  input  oam_pkg::oam_cmd_t             ctl,
  output oam_pkg::oam_stat_t            stat,
  input  logic [oam_pkg::OPCODE_W-1:0]  opcode,
  input  logic [oam_pkg::RANGE_W-1:0]   range_value,
  input  logic [oam_pkg::CODE_W-1:0]    sample_code,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic [oam_pkg::KIND_W-1:0]    result_kind,
  output logic [2:0]                    mux_select,
  output logic                          stage_select,
  output logic [oam_pkg::CODE_W-1:0]    average_code,
  output logic [oam_pkg::UV_W-1:0]      level_uv,
  output logic [oam_pkg::RANGE_W-1:0]   measured_range,
  output logic [oam_pkg::RANGE_W-1:0]   next_range
);

  localparam logic [oam_pkg::CNT_W-1:0] MAX_CNT = oam_pkg::CNT_W'(MAX_OVERSAMPLE);

  logic [oam_pkg::CNT_W-1:0]   oversample_count;
  logic                        autoscale_enable;
  logic [oam_pkg::UV_W-1:0]    low_threshold_uv;
  logic [oam_pkg::UV_W-1:0]    high_threshold_uv;
  logic                        amplifier_on;

  logic [oam_pkg::SUM_W-1:0]   sample_sum;
  logic [oam_pkg::CNT_W-1:0]   sample_count;
  logic [oam_pkg::RANGE_W-1:0] gain_range;
  logic [oam_pkg::RANGE_W-1:0] measure_range;
  logic                        measuring;
  logic [oam_pkg::PROD_W-1:0]  prod;
  logic [oam_pkg::CODE_W-1:0]  avg;

  logic [oam_pkg::CNT_W-1:0]   target;
  logic [oam_pkg::SUM_W-1:0]   sum_add;
  logic [oam_pkg::CNT_W-1:0]   count_inc;
  logic                        last;

  logic [oam_pkg::RANGE_W-1:0] imm_range;
  logic [oam_pkg::KIND_W-1:0]  imm_kind;
  logic                        imm_stage;
  logic [oam_pkg::RANGE_W-1:0] imm_mrange;

  logic [oam_pkg::PROD_W-1:0]  div_q;
  logic [oam_pkg::CNT_W-1:0]   div_r;
  logic                        div_done;
  logic [oam_pkg::UV_W-1:0]    uv;
  logic                        frac_nz;
  logic                        step_up;
  logic                        step_dn;
  logic [oam_pkg::RANGE_W-1:0] fin_range;
  logic                        load_imm;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      oversample_count  <= oam_pkg::RST_OVERSAMPLE;
      autoscale_enable  <= 1'b0;
      low_threshold_uv  <= oam_pkg::RST_LOW_THR;
      high_threshold_uv <= oam_pkg::RST_HIGH_THR;
      amplifier_on      <= 1'b1;
    end else if (cfg.valid) begin
      case (cfg.index)
        oam_pkg::REG_OVERSAMPLE: oversample_count  <= cfg.data[oam_pkg::CNT_W-1:0];
        oam_pkg::REG_AUTOSCALE:  autoscale_enable  <= cfg.data[0];
        oam_pkg::REG_LOW_THR:    low_threshold_uv  <= cfg.data[oam_pkg::UV_W-1:0];
        oam_pkg::REG_HIGH_THR:   high_threshold_uv <= cfg.data[oam_pkg::UV_W-1:0];
        oam_pkg::REG_AMP_ON:     amplifier_on      <= cfg.data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (oversample_count == '0) begin
      target = oam_pkg::CNT_W'(1);
    end else if (oversample_count > MAX_CNT) begin
      target = MAX_CNT;
    end else begin
      target = oversample_count;
    end
  end

  assign sum_add   = sample_sum + oam_pkg::SUM_W'(sample_code[SAMPLE_BITS-1:0]);
  assign count_inc = sample_count + oam_pkg::CNT_W'(1);
  assign last      = (opcode == oam_pkg::OP_SAMPLE) && measuring && (count_inc >= target);

  always_comb begin
    imm_range  = gain_range;
    imm_kind   = oam_pkg::KIND_IGNORED;
    imm_stage  = gain_range[0];
    imm_mrange = '0;
    case (opcode)
      oam_pkg::OP_SET_RANGE: begin
        imm_range = range_value;
        imm_kind  = oam_pkg::KIND_APPLIED;
        imm_stage = range_value[0];
      end
      oam_pkg::OP_START: begin
        imm_kind   = oam_pkg::KIND_REQUEST;
        imm_mrange = gain_range;
      end
      oam_pkg::OP_SAMPLE: begin
        if (measuring) begin
          imm_kind   = oam_pkg::KIND_REQUEST;
          imm_stage  = measure_range[0];
          imm_mrange = measure_range;
        end
      end
      default: ;
    endcase
  end

  oam_div #(
    .DW(oam_pkg::PROD_W),
    .VW(oam_pkg::CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.div_start),
    .dividend (ctl.div_num ? prod : oam_pkg::PROD_W'(sample_sum)),
    .divisor  (sample_count),
    .quo      (div_q),
    .rem      (div_r),
    .done     (div_done)
  );

  // exact level lies above uv when either division left a remainder
  assign uv      = div_q[SAMPLE_BITS +: oam_pkg::UV_W];
  assign frac_nz = (|div_q[SAMPLE_BITS-1:0]) || (|div_r);
  assign step_up = autoscale_enable && (uv < low_threshold_uv) &&
                   (measure_range != oam_pkg::RANGE_MAX);
  assign step_dn = autoscale_enable &&
                   ((uv > high_threshold_uv) || ((uv == high_threshold_uv) && frac_nz)) &&
                   (measure_range != oam_pkg::RANGE_MIN);

  always_comb begin
    if (step_up) begin
      fin_range = measure_range + oam_pkg::RANGE_W'(1);
    end else if (step_dn) begin
      fin_range = measure_range - oam_pkg::RANGE_W'(1);
    end else begin
      fin_range = gain_range;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_sum    <= '0;
      sample_count  <= '0;
      gain_range    <= '0;
      measure_range <= '0;
      measuring     <= 1'b0;
    end else if (ctl.accept) begin
      case (opcode)
        oam_pkg::OP_SET_RANGE: gain_range <= range_value;
        oam_pkg::OP_START: begin
          measure_range <= gain_range;
          sample_sum    <= '0;
          sample_count  <= '0;
          measuring     <= 1'b1;
        end
        oam_pkg::OP_SAMPLE: begin
          if (measuring) begin
            sample_sum   <= sum_add;
            sample_count <= count_inc;
            measuring    <= !last;
          end
        end
        default: ;
      endcase
    end else if (ctl.finish) begin
      gain_range <= fin_range;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_prod) begin
      prod <= oam_pkg::PROD_W'(oam_pkg::FULL_SCALE_UV) * oam_pkg::PROD_W'(sample_sum);
    end
    if (ctl.store_avg) begin
      avg <= div_q[oam_pkg::CODE_W-1:0];
    end
  end

  assign load_imm = ctl.accept && !last;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_imm || ctl.finish) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_imm) begin
      result_kind    <= imm_kind;
      mux_select     <= oam_pkg::mux_code(imm_range, amplifier_on);
      stage_select   <= imm_stage;
      average_code   <= '0;
      level_uv       <= '0;
      measured_range <= imm_mrange;
      next_range     <= imm_range;
    end else if (ctl.finish) begin
      result_kind    <= oam_pkg::KIND_DONE;
      mux_select     <= oam_pkg::mux_code(fin_range, amplifier_on);
      stage_select   <= measure_range[0];
      average_code   <= avg;
      level_uv       <= uv;
      measured_range <= measure_range;
      next_range     <= fin_range;
    end
  end

  assign stat.last_sample = last;
  assign stat.div_done    = div_done;
  assign stat.out_free    = !res_valid || res_ready;

  a_fin_idle: assert property (@(posedge clk) disable iff (rst) ctl.finish |-> !measuring)
    else $error("measurement finished while still marked running");

endmodule

`default_nettype wire

/* hw/rtl/oam_ctrl.sv */
// Controller state machine: item acceptance and sequencing of the final-sample math.
// Depends on oam_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module oam_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  oam_pkg::oam_stat_t stat,
  output oam_pkg::oam_cmd_t  ctl
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_AVG  = 3'd2;
  localparam logic [2:0] S_UV   = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE) && stat.out_free;

  always_comb begin
    ctl.accept    = in_ready && in_valid;
    ctl.load_prod = (state == S_MUL);
    ctl.div_start = (state == S_MUL) || ((state == S_AVG) && stat.div_done);
    ctl.div_num   = (state == S_AVG);
    ctl.store_avg = (state == S_AVG) && stat.div_done;
    ctl.finish    = (state == S_FIN) && stat.out_free;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (ctl.accept && stat.last_sample) state_next = S_MUL;
      S_MUL:  state_next = S_AVG;
      S_AVG:  if (stat.div_done) state_next = S_UV;
      S_UV:   if (stat.div_done) state_next = S_FIN;
      S_FIN:  if (stat.out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst) in_ready |-> state == S_IDLE)
    else $error("ready raised outside idle");
  a_fin_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) && !stat.out_free |=> state == S_FIN)
    else $error("final result dropped while output register full");
  a_last_seq: assert property (@(posedge clk) disable iff (rst)
    ctl.accept && stat.last_sample |=> state == S_MUL)
    else $error("last sample did not start the result sequence");

endmodule

`default_nettype wire

/* hw/rtl/oversampled_adc_autorange_meter.sv */
// Top level of the oversampled ADC autorange meter.
// Depends on oam_pkg, oam_if, oam_ctrl and oam_datapath.
//
// Set-range, start and sample items each leave their result in an output register; the
// next item is taken once that result has left or leaves in the same cycle.
// The sample that completes a measurement leaves no immediate result: one shared
// bit-serial divider, one bit per cycle over a 46-bit dividend, runs first for the mean
// code and then for the microvolt level (3300000*sum divided by the sample count, then
// by 2^SAMPLE_BITS), after which the autoscale step is applied once the output register is free.
// Registers are to take writes only while the block is idle; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module oversampled_adc_autorange_meter #(
  parameter int SAMPLE_BITS    = 16,
  parameter int MAX_OVERSAMPLE = 255
) (
  input  logic       clk,
  input  logic       rst,
  oam_cfg_if.sink    cfg,
  oam_cmd_if.sink    cmd,
  oam_res_if.source  res
);

  oam_pkg::oam_cmd_t  ctl;
  oam_pkg::oam_stat_t stat;
  logic               in_ready;

  assign cmd.ready = in_ready;

  oam_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  oam_datapath #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .MAX_OVERSAMPLE (MAX_OVERSAMPLE)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .ctl            (ctl),
    .stat           (stat),
    .opcode         (cmd.opcode),
    .range_value    (cmd.range_value),
    .sample_code    (cmd.sample_code),
    .res_valid      (res.valid),
    .res_ready      (res.ready),
    .result_kind    (res.result_kind),
    .mux_select     (res.mux_select),
    .stage_select   (res.stage_select),
    .average_code   (res.average_code),
    .level_uv       (res.level_uv),
    .measured_range (res.measured_range),
    .next_range     (res.next_range)
  );

endmodule

`default_nettype wire

/* sim/testbench.sv */
// Self-checking testbench for oversampled_adc_autorange_meter: directed items from a table,
// then random measurement sequences under several register settings, checked by a predictor.
// Depends on oam_pkg, oam_if and the RTL of the block.
`timescale 1ns / 1ps

module testbench;

  localparam logic [oam_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 40;
  localparam int BIG_PHASE = 2;

  typedef struct packed {
    logic [oam_pkg::KIND_W-1:0]  kind;
    logic [2:0]                  mux;
    logic                        stage;
    logic [oam_pkg::CODE_W-1:0]  avg;
    logic [oam_pkg::UV_W-1:0]    uv;
    logic [oam_pkg::RANGE_W-1:0] mrange;
    logic [oam_pkg::RANGE_W-1:0] nrange;
  } reading_t;

  typedef struct packed {
    bit                             is_write;
    logic [oam_pkg::REG_IDX_W-1:0]  reg_idx;
    logic [oam_pkg::REG_DATA_W-1:0] reg_val;
    logic [oam_pkg::OPCODE_W-1:0]   op;
    logic [oam_pkg::RANGE_W-1:0]    rng;
    logic [oam_pkg::CODE_W-1:0]     code;
    bit                             typed;
    reading_t                       want;
  } plan_row_t;

  logic clk;
  logic rst;

  oam_cmd_if cmd_ch();
  oam_res_if res_ch();
  oam_cfg_if cfg_ch();

  oversampled_adc_autorange_meter u_top (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_ch),
    .cmd(cmd_ch),
    .res(res_ch)
  );

  reading_t  pending_readings[$];
  plan_row_t plan[$];
  int        errors;
  int        cycle_count;
  bit        calm;

  logic [oam_pkg::SUM_W-1:0]   acc_sum;
  logic [oam_pkg::CNT_W-1:0]   acc_cnt;
  logic [oam_pkg::RANGE_W-1:0] gain_rng;
  logic [oam_pkg::RANGE_W-1:0] meas_rng;
  logic                        busy;

  logic [oam_pkg::CNT_W-1:0] os_count;
  logic                      auto_on;
  logic [oam_pkg::UV_W-1:0]  low_thr;
  logic [oam_pkg::UV_W-1:0]  high_thr;
  logic                      amp_on;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic reading_t predict_reading(input logic [oam_pkg::OPCODE_W-1:0] op,
                                               input logic [oam_pkg::RANGE_W-1:0] rng,
                                               input logic [oam_pkg::CODE_W-1:0] code);
    reading_t r;
    logic [oam_pkg::CNT_W-1:0] goal;
    longint unsigned num;
    longint unsigned den;
    longint unsigned lvl;
    r = '0;
    goal = (os_count == '0) ? 8'd1 : os_count;
    if (op == oam_pkg::OP_SET_RANGE) begin
      gain_rng = rng;
      r.kind = oam_pkg::KIND_APPLIED;
      r.stage = gain_rng[0];
    end else if (op == oam_pkg::OP_START) begin
      meas_rng = gain_rng;
      acc_sum = '0;
      acc_cnt = '0;
      busy = 1'b1;
      r.kind = oam_pkg::KIND_REQUEST;
      r.stage = meas_rng[0];
      r.mrange = meas_rng;
    end else if (op == oam_pkg::OP_SAMPLE && busy) begin
      acc_sum = acc_sum + oam_pkg::SUM_W'(code);
      acc_cnt = acc_cnt + 1'b1;
      r.kind = oam_pkg::KIND_REQUEST;
      r.stage = meas_rng[0];
      r.mrange = meas_rng;
      if (acc_cnt >= goal) begin
        num = 64'(oam_pkg::FULL_SCALE_UV);
        num = num * 64'(acc_sum);
        den = 64'(acc_cnt);
        den = den << oam_pkg::CODE_W;
        lvl = num / den;
        r.avg = oam_pkg::CODE_W'(acc_sum / oam_pkg::SUM_W'(acc_cnt));
        r.uv = lvl[oam_pkg::UV_W-1:0];
        if (auto_on && lvl < 64'(low_thr) && meas_rng != oam_pkg::RANGE_MAX) begin
          gain_rng = meas_rng + 1'b1;
        end else if (auto_on && (lvl > 64'(high_thr) ||
                                 (lvl == 64'(high_thr) && num % den != 0))
                     && meas_rng != oam_pkg::RANGE_MIN) begin
          gain_rng = meas_rng - 1'b1;
        end
        busy = 1'b0;
        r.kind = oam_pkg::KIND_DONE;
      end
    end else begin
      r.kind = oam_pkg::KIND_IGNORED;
      r.stage = gain_rng[0];
    end
    case (gain_rng[2:1])
      2'd0: r.mux = oam_pkg::MUX_TZ0;
      2'd1: r.mux = oam_pkg::MUX_TZ1;
      2'd2: r.mux = oam_pkg::MUX_TZ2;
      default: r.mux = oam_pkg::MUX_TZ3;
    endcase
    if (!amp_on) r.mux = '0;
    r.nrange = gain_rng;
    return r;
  endfunction

  function automatic plan_row_t row_item(input logic [oam_pkg::OPCODE_W-1:0] op,
                                         input logic [oam_pkg::RANGE_W-1:0] rng,
                                         input logic [oam_pkg::CODE_W-1:0] code);
    plan_row_t p;
    p = '0;
    p.op = op;
    p.rng = rng;
    p.code = code;
    return p;
  endfunction

  function automatic plan_row_t row_typed(input logic [oam_pkg::OPCODE_W-1:0] op,
                                          input logic [oam_pkg::RANGE_W-1:0] rng,
                                          input logic [oam_pkg::CODE_W-1:0] code,
                                          input logic [oam_pkg::KIND_W-1:0] kind,
                                          input logic [2:0] mux, input logic stage,
                                          input logic [oam_pkg::CODE_W-1:0] avg,
                                          input logic [oam_pkg::UV_W-1:0] uv,
                                          input logic [oam_pkg::RANGE_W-1:0] mrange,
                                          input logic [oam_pkg::RANGE_W-1:0] nrange);
    plan_row_t p;
    p = row_item(op, rng, code);
    p.typed = 1'b1;
    p.want = '{kind, mux, stage, avg, uv, mrange, nrange};
    return p;
  endfunction

  function automatic plan_row_t row_reg(input logic [oam_pkg::REG_IDX_W-1:0] idx,
                                        input logic [oam_pkg::REG_DATA_W-1:0] val);
    plan_row_t p;
    p = '0;
    p.is_write = 1'b1;
    p.reg_idx = idx;
    p.reg_val = val;
    return p;
  endfunction

  function automatic logic [oam_pkg::CODE_W-1:0] random_code();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: return oam_pkg::CODE_W'($urandom_range(0, 255));
      default: return oam_pkg::CODE_W'($urandom);
    endcase
  endfunction

  function automatic logic [oam_pkg::UV_W-1:0] pick_level(input bit upper);
    case ($urandom_range(0, 5))
      0: return '0;
      1: return oam_pkg::FULL_SCALE_UV;
      default: return upper ? oam_pkg::UV_W'($urandom_range(1650000, 3300000))
                            : oam_pkg::UV_W'($urandom_range(0, 1650000));
    endcase
  endfunction

  function automatic void check_field(input string name, input longint unsigned want,
                                      input longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  task automatic wait_drain();
    @(negedge clk);
    cmd_ch.valid = 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [oam_pkg::REG_IDX_W-1:0] idx,
                           input logic [oam_pkg::REG_DATA_W-1:0] val);
    wait_drain();
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data = val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      oam_pkg::REG_OVERSAMPLE: os_count = val[oam_pkg::CNT_W-1:0];
      oam_pkg::REG_AUTOSCALE:  auto_on = val[0];
      oam_pkg::REG_LOW_THR:    low_thr = val[oam_pkg::UV_W-1:0];
      oam_pkg::REG_HIGH_THR:   high_thr = val[oam_pkg::UV_W-1:0];
      oam_pkg::REG_AMP_ON:     amp_on = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic send_item(input logic [oam_pkg::OPCODE_W-1:0] op,
                           input logic [oam_pkg::RANGE_W-1:0] rng,
                           input logic [oam_pkg::CODE_W-1:0] code, input bit typed,
                           input reading_t want);
    reading_t got;
    if (!calm && $urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 10)) begin
        @(negedge clk);
        cmd_ch.valid = 1'b0;
      end
    end
    @(negedge clk);
    cmd_ch.valid = 1'b1;
    cmd_ch.opcode = op;
    cmd_ch.range_value = rng;
    cmd_ch.sample_code = code;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    got = predict_reading(op, rng, code);
    pending_readings.push_back(typed ? want : got);
  endtask

  task automatic push_cmd(input logic [oam_pkg::OPCODE_W-1:0] op,
                          input logic [oam_pkg::RANGE_W-1:0] rng,
                          input logic [oam_pkg::CODE_W-1:0] code);
    send_item(op, rng, code, 1'b0, '0);
  endtask

  // result side: random stall bursts, none in the final phase
  initial begin
    int stall;
    stall = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        stall--;
        res_ch.ready = 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 10) - 1;
        res_ch.ready = 1'b0;
      end else begin
        res_ch.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    reading_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_readings.size() == 0) begin
        $error("result with no item waiting: result_kind %0d", res_ch.result_kind);
        errors++;
      end else begin
        want = pending_readings.pop_front();
        check_field("result_kind", want.kind, res_ch.result_kind);
        check_field("mux_select", want.mux, res_ch.mux_select);
        check_field("stage_select", want.stage, res_ch.stage_select);
        check_field("average_code", want.avg, res_ch.average_code);
        check_field("level_uv", want.uv, res_ch.level_uv);
        check_field("measured_range", want.mrange, res_ch.measured_range);
        check_field("next_range", want.nrange, res_ch.next_range);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int goal;
    int sent;
    int n;
    int pick;
    rst = 1'b1;
    cmd_ch.valid = 1'b0;
    cmd_ch.opcode = oam_pkg::OP_SET_RANGE;
    cmd_ch.range_value = '0;
    cmd_ch.sample_code = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = oam_pkg::REG_OVERSAMPLE;
    cfg_ch.data = '0;
    errors = 0;
    cycle_count = 0;
    calm = 1'b0;
    acc_sum = '0;
    acc_cnt = '0;
    gain_rng = oam_pkg::RANGE_MIN;
    meas_rng = oam_pkg::RANGE_MIN;
    busy = 1'b0;
    os_count = oam_pkg::RST_OVERSAMPLE;
    auto_on = 1'b0;
    low_thr = oam_pkg::RST_LOW_THR;
    high_thr = oam_pkg::RST_HIGH_THR;
    amp_on = 1'b1;

    plan.push_back(row_typed(oam_pkg::OP_SAMPLE, 3'd0, 16'h1234, oam_pkg::KIND_IGNORED,
                             oam_pkg::MUX_TZ0, 1'b0, '0, '0, '0, 3'd0));
    plan.push_back(row_typed(OP_UNUSED, 3'd7, 16'hFFFF, oam_pkg::KIND_IGNORED,
                             oam_pkg::MUX_TZ0, 1'b0, '0, '0, '0, 3'd0));
    plan.push_back(row_typed(oam_pkg::OP_SET_RANGE, 3'd7, 16'hFFFF, oam_pkg::KIND_APPLIED,
                             oam_pkg::MUX_TZ3, 1'b1, '0, '0, '0, 3'd7));
    plan.push_back(row_typed(oam_pkg::OP_SET_RANGE, 3'd3, 16'h0000, oam_pkg::KIND_APPLIED,
                             oam_pkg::MUX_TZ1, 1'b1, '0, '0, '0, 3'd3));
    plan.push_back(row_typed(oam_pkg::OP_SET_RANGE, 3'd4, 16'h5A5A, oam_pkg::KIND_APPLIED,
                             oam_pkg::MUX_TZ2, 1'b0, '0, '0, '0, 3'd4));
    plan.push_back(row_reg(oam_pkg::REG_OVERSAMPLE, 22'd1));
    plan.push_back(row_typed(oam_pkg::OP_START, 3'd0, 16'h0000, oam_pkg::KIND_REQUEST,
                             oam_pkg::MUX_TZ2, 1'b0, '0, '0, 3'd4, 3'd4));
    plan.push_back(row_typed(oam_pkg::OP_SAMPLE, 3'd0, 16'hFFFF, oam_pkg::KIND_DONE,
                             oam_pkg::MUX_TZ2, 1'b0, 16'hFFFF, 22'd3299949, 3'd4, 3'd4));
    // count of zero behaves as one
    plan.push_back(row_reg(oam_pkg::REG_OVERSAMPLE, 22'd0));
    plan.push_back(row_reg(oam_pkg::REG_AUTOSCALE, 22'd1));
    plan.push_back(row_item(oam_pkg::OP_START, 3'd2, 16'h0F0F));
    plan.push_back(row_typed(oam_pkg::OP_SAMPLE, 3'd0, 16'h0000, oam_pkg::KIND_DONE,
                             oam_pkg::MUX_TZ2, 1'b0, '0, '0, 3'd4, 3'd5));
    plan.push_back(row_item(oam_pkg::OP_SET_RANGE, 3'd7, 16'h0000));
    plan.push_back(row_item(oam_pkg::OP_START, 3'd0, 16'h0000));
    plan.push_back(row_item(oam_pkg::OP_SAMPLE, 3'd0, 16'h0000));
    plan.push_back(row_item(oam_pkg::OP_SET_RANGE, 3'd0, 16'h0000));
    plan.push_back(row_item(oam_pkg::OP_START, 3'd0, 16'h0000));
    plan.push_back(row_item(oam_pkg::OP_SAMPLE, 3'd0, 16'hFFFF));
    plan.push_back(row_item(oam_pkg::OP_SET_RANGE, 3'd3, 16'h0000));
    plan.push_back(row_item(oam_pkg::OP_START, 3'd0, 16'h0000));
    plan.push_back(row_item(oam_pkg::OP_SAMPLE, 3'd0, 16'hFFFF));
    // level equal to the high threshold with a remainder steps down
    plan.push_back(row_reg(oam_pkg::REG_LOW_THR, 22'd0));
    plan.push_back(row_reg(oam_pkg::REG_HIGH_THR, 22'd50));
    plan.push_back(row_item(oam_pkg::OP_START, 3'd0, 16'h0000));
    plan.push_back(row_item(oam_pkg::OP_SAMPLE, 3'd0, 16'h0001));
    plan.push_back(row_reg(oam_pkg::REG_LOW_THR, 22'd3300000));
    plan.push_back(row_reg(oam_pkg::REG_HIGH_THR, 22'd0));
    plan.push_back(row_item(oam_pkg::OP_START, 3'd0, 16'h0000));
    plan.push_back(row_item(oam_pkg::OP_SAMPLE, 3'd0, 16'h0064));
    plan.push_back(row_reg(oam_pkg::REG_AMP_ON, 22'd0));
    plan.push_back(row_reg(oam_pkg::REG_OVERSAMPLE, 22'd2));
    plan.push_back(row_typed(oam_pkg::OP_SET_RANGE, 3'd6, 16'h0000, oam_pkg::KIND_APPLIED,
                             '0, 1'b0, '0, '0, '0, 3'd6));
    plan.push_back(row_item(oam_pkg::OP_START, 3'd0, 16'h0000));
    plan.push_back(row_item(oam_pkg::OP_SAMPLE, 3'd0, 16'h8000));
    plan.push_back(row_item(oam_pkg::OP_START, 3'd0, 16'h0000));
    plan.push_back(row_item(oam_pkg::OP_SET_RANGE, 3'd1, 16'h0000));
    plan.push_back(row_item(oam_pkg::OP_SAMPLE, 3'd0, 16'h00FF));
    plan.push_back(row_item(oam_pkg::OP_SAMPLE, 3'd0, 16'hFF00));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        send_item(plan[i].op, plan[i].rng, plan[i].code, plan[i].typed, plan[i].want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      calm = (ph == PHASES - 1);
      if (ph == BIG_PHASE) begin
        write_reg(oam_pkg::REG_OVERSAMPLE, 22'd255);
      end else begin
        case ($urandom_range(0, 9))
          0: write_reg(oam_pkg::REG_OVERSAMPLE, 22'd0);
          1: write_reg(oam_pkg::REG_OVERSAMPLE, 22'd1);
          default: write_reg(oam_pkg::REG_OVERSAMPLE,
                             oam_pkg::REG_DATA_W'($urandom_range(2, 8)));
        endcase
      end
      if (ph == 0 || $urandom_range(0, 1))
        write_reg(oam_pkg::REG_AUTOSCALE, oam_pkg::REG_DATA_W'($urandom_range(0, 3) != 0));
      if (ph == 0 || $urandom_range(0, 1))
        write_reg(oam_pkg::REG_LOW_THR, pick_level(1'b0));
      if (ph == 0 || $urandom_range(0, 1))
        write_reg(oam_pkg::REG_HIGH_THR, pick_level(1'b1));
      if (ph == 0 || $urandom_range(0, 1))
        write_reg(oam_pkg::REG_AMP_ON, oam_pkg::REG_DATA_W'($urandom_range(0, 1)));
      goal = (os_count == '0) ? 1 : int'(os_count);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) < 8) begin
          if ($urandom_range(0, 1)) begin
            push_cmd(oam_pkg::OP_SET_RANGE, oam_pkg::RANGE_W'($urandom_range(0, 7)),
                     oam_pkg::CODE_W'($urandom));
            sent++;
          end
          push_cmd(oam_pkg::OP_START, oam_pkg::RANGE_W'($urandom_range(0, 7)),
                   oam_pkg::CODE_W'($urandom));
          sent++;
          n = 0;
          while (n < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
              push_cmd(oam_pkg::OP_SET_RANGE, oam_pkg::RANGE_W'($urandom_range(0, 7)),
                       oam_pkg::CODE_W'($urandom));
            end else if (pick < 9 && goal <= 16) begin
              push_cmd(oam_pkg::OP_START, oam_pkg::RANGE_W'($urandom_range(0, 7)),
                       oam_pkg::CODE_W'($urandom));
              n = 0;
            end else if (pick < 11) begin
              push_cmd(OP_UNUSED, oam_pkg::RANGE_W'($urandom_range(0, 7)),
                       oam_pkg::CODE_W'($urandom));
            end else begin
              push_cmd(oam_pkg::OP_SAMPLE, oam_pkg::RANGE_W'($urandom_range(0, 7)),
                       random_code());
              n++;
            end
            sent++;
          end
        end else begin
          push_cmd(oam_pkg::OPCODE_W'($urandom_range(0, 3)),
                   oam_pkg::RANGE_W'($urandom_range(0, 7)), random_code());
          sent++;
        end
        if ($urandom_range(0, 49) == 0) wait_drain();
      end
    end

    wait_drain();
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/oam_pkg.sv
hw/rtl/oam_if.sv
hw/rtl/oam_div.sv
hw/rtl/oam_datapath.sv
hw/rtl/oam_ctrl.sv
hw/rtl/oversampled_adc_autorange_meter.sv
sim/testbench.sv
